// ----- hw/rtl/pcm_box_decimator_defines.svh -----
// ----------------------------------------------------------------------------
// pcm_box_decimator_defines: assertion macros
// Concurrent assertion wrappers clocked on clk_i and held off during reset.
// ----------------------------------------------------------------------------
`ifndef PCM_BOX_DECIMATOR_DEFINES_SVH
`define PCM_BOX_DECIMATOR_DEFINES_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge out of reset
`define PBD_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// condition must never be seen out of reset
`define PBD_ASSERT_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define PBD_ASSERT(name, prop, msg)
`define PBD_ASSERT_NEVER(name, cond, msg)
`endif

`endif

// ----- hw/rtl/pbd_pkg.sv -----
// ----------------------------------------------------------------------------
// pbd_pkg
// Shared types, constants and the sample cut function of the box decimator.
// ----------------------------------------------------------------------------
`default_nettype none

package pbd_pkg;

  // default parameter values
  localparam int unsigned OUT_RATE_DEF  = 44100;
  localparam int unsigned MAX_GROUP_DEF = 24;

  // register reset values
  localparam int unsigned SRC_RATE_RST     = 44100;
  localparam int unsigned SAMPLE_BYTES_RST = 2;

  // tenths of a second per output sample, scaled by the output rate
  localparam int unsigned TIME_STEP = 10;

  // widths
  localparam int unsigned RAW_W     = 24;
  localparam int unsigned SMP_W     = 16;
  localparam int unsigned RATE_W    = 18;
  localparam int unsigned FRAC_W    = 17;  // holds any remainder below 96000
  localparam int unsigned WHOLE_W   = 6;   // holds the quotient for rates above 8000
  localparam int unsigned GROUP_W   = 5;
  localparam int unsigned SUM_W     = 22;
  localparam int unsigned MAG_W     = SUM_W - 1;
  localparam int unsigned TENTHS_W  = 24;
  localparam int unsigned REG_IDX_W = 2;
  localparam int unsigned SB_W      = 2;

  // register indexes
  typedef enum logic [REG_IDX_W-1:0] {
    REG_SAMPLE_BYTES = 2'd0,
    REG_MONO_SOURCE  = 2'd1,
    REG_SOURCE_RATE  = 2'd2
  } reg_idx_e;

  // back end sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_DONE
  } back_state_e;

  // configuration as seen by the front end
  typedef struct packed {
    logic [SB_W-1:0]    sample_bytes;
    logic               mono;
    logic [WHOLE_W-1:0] whole;
    logic [FRAC_W-1:0]  rem;
    logic               clr_frac;
    logic               busy;
  } cfg_t;

  // one finished group on its way to the divider
  typedef struct packed {
    logic signed [SUM_W-1:0] sum_l;
    logic signed [SUM_W-1:0] sum_r;
    logic [GROUP_W-1:0]      cnt;
  } grp_t;

  // cut a raw little-endian sample down to a signed 16-bit value
  function automatic logic signed [SMP_W-1:0] cut_sample(
    input logic [SB_W-1:0]  nbytes,
    input logic [RAW_W-1:0] raw
  );
    logic [SMP_W-1:0] v;
    unique case (nbytes)
      2'd1:    v = {raw[7:0], 8'h00};
      2'd2:    v = raw[15:0];
      2'd3:    v = raw[23:8];
      default: v = '0;
    endcase
    return $signed(v);
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/pcm_box_decimator.sv -----
// ----------------------------------------------------------------------------
// pcm_box_decimator
// Averaging decimator from a source PCM rate to a fixed output rate.
// ----------------------------------------------------------------------------
// The front end takes one source frame per cycle whenever its two-entry group
// queue has room and no rate split is running; the back end works on one group
// at a time (one load, 21 restoring divide steps for both channels side by side,
// one result write that waits while the output is held), so it takes no new
// group before the last one is written. A write of source_rate occupies the
// config port while the rate is split; no frame is taken in that time.
`default_nettype none

`include "pcm_box_decimator_defines.svh"

module pcm_box_decimator #(
  parameter int unsigned OutRate  = pbd_pkg::OUT_RATE_DEF,
  parameter int unsigned MaxGroup = pbd_pkg::MAX_GROUP_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // source frames
  input  wire logic                          s_axis_tvalid,
  output      logic                          s_axis_tready,
  input  wire logic [47:0]                   s_axis_tdata,  // raw_left, raw_right
  // averaged output samples
  output      logic                          m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output      logic [55:0]                   m_axis_tdata,  // out_left, out_right, elapsed_tenths
  // register writes
  input  wire logic                          cfg_valid_i,
  output      logic                          cfg_ready_o,
  input  wire logic [pbd_pkg::REG_IDX_W-1:0] cfg_index_i,
  input  wire logic [pbd_pkg::RATE_W-1:0]    cfg_data_i
);
  import pbd_pkg::*;

  cfg_t                  cfg;
  grp_t                  grp_in, grp_out;
  logic                  push, pop, fifo_full, fifo_empty;
  logic signed [SMP_W-1:0] out_l, out_r;
  logic [TENTHS_W-1:0]   elapsed;

  // configuration and rate split
  pbd_cfg #(.OutRate(OutRate)) u_cfg (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i,
    .cfg_o (cfg)
  );

  // frame intake and group sums
  pbd_front #(.OutRate(OutRate), .MaxGroup(MaxGroup)) u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .raw_left_i  (s_axis_tdata[RAW_W-1:0]),
    .raw_right_i (s_axis_tdata[2*RAW_W-1:RAW_W]),
    .cfg_i       (cfg),
    .full_i      (fifo_full),
    .push_o      (push),
    .grp_o       (grp_in)
  );

  // group queue
  pbd_fifo u_fifo (
    .clk_i,
    .rst_ni,
    .push_i  (push),
    .wdata_i (grp_in),
    .pop_i   (pop),
    .rdata_o (grp_out),
    .full_o  (fifo_full),
    .empty_o (fifo_empty)
  );

  // divide and time stamp
  pbd_back #(.OutRate(OutRate)) u_back (
    .clk_i,
    .rst_ni,
    .grp_i       (grp_out),
    .empty_i     (fifo_empty),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_left_o  (out_l),
    .out_right_o (out_r),
    .elapsed_o   (elapsed)
  );

  assign m_axis_tdata = {elapsed, out_r, out_l};

  // checks
  `PBD_ASSERT_NEVER(a_fifo_overflow, push && fifo_full && !pop, "group queue overflow")
  `PBD_ASSERT_NEVER(a_fifo_underflow, pop && fifo_empty, "group queue underflow")
  `PBD_ASSERT_NEVER(a_frame_while_split, s_axis_tvalid && s_axis_tready && cfg.busy, "frame taken during rate split")
  `PBD_ASSERT(a_group_size, push |-> (grp_in.cnt != '0) && (grp_in.cnt <= GROUP_W'(MaxGroup)), "group size out of range")

endmodule

`default_nettype wire

// ----- hw/rtl/pbd_cfg.sv -----
// ----------------------------------------------------------------------------
// pbd_cfg
// Configuration registers and the serial split of the source rate into
// whole and remainder parts of source_rate / OutRate.
// ----------------------------------------------------------------------------
`default_nettype none

module pbd_cfg #(
  parameter int unsigned OutRate = pbd_pkg::OUT_RATE_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_valid_i,
  output      logic                           cfg_ready_o,
  input  wire logic [pbd_pkg::REG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [pbd_pkg::RATE_W-1:0]     cfg_data_i,
  output      pbd_pkg::cfg_t                  cfg_o
);
  import pbd_pkg::*;

  localparam logic [RATE_W-1:0]  OutRateV  = RATE_W'(OutRate);
  localparam logic [RATE_W-1:0]  RemRst    = RATE_W'(SRC_RATE_RST % OutRate);
  localparam logic [WHOLE_W-1:0] WholeRst  = WHOLE_W'(SRC_RATE_RST / OutRate);

  logic [SB_W-1:0]    sample_bytes_q;
  logic               mono_q;
  logic [RATE_W-1:0]  rem_q;
  logic [WHOLE_W-1:0] whole_q;
  logic               busy_q;
  logic               clr_q;
  logic               wr;

  assign wr          = cfg_valid_i && !busy_q;
  assign cfg_ready_o = !busy_q;

  // register writes and repeated subtraction of the output rate
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_bytes_q <= SB_W'(SAMPLE_BYTES_RST);
      mono_q         <= 1'b0;
      rem_q          <= RemRst;
      whole_q        <= WholeRst;
      busy_q         <= 1'b0;
      clr_q          <= 1'b0;
    end else begin
      clr_q <= 1'b0;
      if (busy_q) begin
        if (rem_q >= OutRateV) begin
          rem_q   <= rem_q - OutRateV;
          whole_q <= whole_q + WHOLE_W'(1);
        end else begin
          busy_q <= 1'b0;
        end
      end else if (wr) begin
        unique case (cfg_index_i)
          REG_SAMPLE_BYTES: sample_bytes_q <= cfg_data_i[SB_W-1:0];
          REG_MONO_SOURCE:  mono_q <= cfg_data_i[0];
          REG_SOURCE_RATE: begin
            rem_q   <= cfg_data_i;
            whole_q <= '0;
            busy_q  <= 1'b1;
            clr_q   <= 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  assign cfg_o.sample_bytes = sample_bytes_q;
  assign cfg_o.mono         = mono_q;
  assign cfg_o.whole        = whole_q;
  assign cfg_o.rem          = rem_q[FRAC_W-1:0];
  assign cfg_o.clr_frac     = clr_q;
  assign cfg_o.busy         = busy_q;

endmodule

`default_nettype wire

// ----- hw/rtl/pbd_front.sv -----
// ----------------------------------------------------------------------------
// pbd_front
// Takes source frames, sizes each group with the rate accumulator and sums
// both channels; a finished group is pushed into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module pbd_front #(
  parameter int unsigned OutRate  = pbd_pkg::OUT_RATE_DEF,
  parameter int unsigned MaxGroup = pbd_pkg::MAX_GROUP_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output      logic                       in_ready_o,
  input  wire logic [pbd_pkg::RAW_W-1:0]  raw_left_i,
  input  wire logic [pbd_pkg::RAW_W-1:0]  raw_right_i,
  input  wire pbd_pkg::cfg_t              cfg_i,
  input  wire logic                       full_i,
  output      logic                       push_o,
  output      pbd_pkg::grp_t              grp_o
);
  import pbd_pkg::*;

  localparam logic [FRAC_W:0]    OutRateV = (FRAC_W + 1)'(OutRate);
  localparam logic [WHOLE_W:0]   MaxGrpW  = (WHOLE_W + 1)'(MaxGroup);

  logic [GROUP_W-1:0]      frames_q, frames_d;
  logic [GROUP_W-1:0]      target_q, target_d;
  logic signed [SUM_W-1:0] sum_l_q, sum_l_d;
  logic signed [SUM_W-1:0] sum_r_q, sum_r_d;
  logic [FRAC_W-1:0]       frac_q, frac_d;

  logic                    accept;
  logic                    start;
  logic [FRAC_W:0]         frac_sum;
  logic                    frac_ovf;
  logic [WHOLE_W:0]        size_raw;
  logic [GROUP_W-1:0]      size;
  logic [GROUP_W-1:0]      target;
  logic signed [SMP_W-1:0] smp_l, smp_r;
  logic [GROUP_W-1:0]      frames_inc;
  logic                    last;

  assign in_ready_o = !full_i && !cfg_i.busy;
  assign accept     = in_valid_i && in_ready_o;
  assign start      = (frames_q == '0);

  // group size from the fractional rate accumulator
  always_comb begin
    frac_sum = {1'b0, frac_q} + {1'b0, cfg_i.rem};
    frac_ovf = (frac_sum >= OutRateV);
    size_raw = {1'b0, cfg_i.whole} + {{WHOLE_W{1'b0}}, frac_ovf};
    if (size_raw == '0) begin
      size = GROUP_W'(1);
    end else if (size_raw > MaxGrpW) begin
      size = GROUP_W'(MaxGroup);
    end else begin
      size = size_raw[GROUP_W-1:0];
    end
  end

  assign target = start ? size : target_q;

  // sample cut and mono copy
  assign smp_l = cut_sample(cfg_i.sample_bytes, raw_left_i);
  assign smp_r = cfg_i.mono ? smp_l : cut_sample(cfg_i.sample_bytes, raw_right_i);

  assign frames_inc = frames_q + GROUP_W'(1);
  assign last       = (frames_inc >= target);

  // accumulate and close groups
  always_comb begin
    frames_d = frames_q;
    target_d = target_q;
    sum_l_d  = sum_l_q;
    sum_r_d  = sum_r_q;
    frac_d   = frac_q;
    push_o   = 1'b0;
    grp_o.sum_l = (start ? '0 : sum_l_q) + SUM_W'(smp_l);
    grp_o.sum_r = (start ? '0 : sum_r_q) + SUM_W'(smp_r);
    grp_o.cnt   = frames_inc;
    if (accept) begin
      if (start) begin
        target_d = size;
        frac_d   = frac_ovf ? FRAC_W'(frac_sum - OutRateV) : frac_sum[FRAC_W-1:0];
      end
      if (last) begin
        push_o   = 1'b1;
        frames_d = '0;
      end else begin
        frames_d = frames_inc;
        sum_l_d  = grp_o.sum_l;
        sum_r_d  = grp_o.sum_r;
      end
    end
    if (cfg_i.clr_frac) begin
      frac_d = '0;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frames_q <= '0;
      target_q <= '0;
      frac_q   <= '0;
    end else begin
      frames_q <= frames_d;
      target_q <= target_d;
      frac_q   <= frac_d;
    end
  end

  // running sums, only read inside a group
  always_ff @(posedge clk_i) begin
    sum_l_q <= sum_l_d;
    sum_r_q <= sum_r_d;
  end

endmodule

`default_nettype wire

// ----- hw/rtl/pbd_fifo.sv -----
// ----------------------------------------------------------------------------
// pbd_fifo
// Two-entry queue of finished groups between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module pbd_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire pbd_pkg::grp_t wdata_i,
  input  wire logic          pop_i,
  output      pbd_pkg::grp_t rdata_o,
  output      logic          full_o,
  output      logic          empty_o
);
  import pbd_pkg::*;

  localparam int unsigned Depth = 2;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  grp_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q;
  logic [PtrW-1:0] rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + PtrW'(1);
      if (pop_i)  rd_ptr_q <= rd_ptr_q + PtrW'(1);
      priority if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= wdata_i;
  end

endmodule

`default_nettype wire

// ----- hw/rtl/pbd_back.sv -----
// ----------------------------------------------------------------------------
// pbd_back
// Divides both group sums by the frame count with a shared-sequence
// restoring divider, advances the tenths counter and holds the result.
// ----------------------------------------------------------------------------
`default_nettype none

module pbd_back #(
  parameter int unsigned OutRate = pbd_pkg::OUT_RATE_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire pbd_pkg::grp_t                 grp_i,
  input  wire logic                          empty_i,
  output      logic                          pop_o,
  output      logic                          out_valid_o,
  input  wire logic                          out_ready_i,
  output      logic signed [pbd_pkg::SMP_W-1:0] out_left_o,
  output      logic signed [pbd_pkg::SMP_W-1:0] out_right_o,
  output      logic [pbd_pkg::TENTHS_W-1:0]  elapsed_o
);
  import pbd_pkg::*;

  localparam int unsigned   StepW    = $clog2(MAG_W);
  localparam logic [StepW-1:0] LastStep = StepW'(MAG_W - 1);
  localparam logic [FRAC_W:0]  OutRateV = (FRAC_W + 1)'(OutRate);

  back_state_e state_q, state_d;

  logic [MAG_W-1:0]    dvd_l_q, dvd_r_q;
  logic [GROUP_W-1:0]  rem_l_q, rem_r_q;
  logic [GROUP_W-1:0]  div_q;
  logic                neg_l_q, neg_r_q;
  logic [StepW-1:0]    step_q;
  logic [FRAC_W-1:0]   tfrac_q;
  logic [TENTHS_W-1:0] tenths_q;
  logic                out_valid_q;
  logic signed [SMP_W-1:0] out_l_q, out_r_q;
  logic [TENTHS_W-1:0] elapsed_q;

  logic load, step, wr_out;
  logic [GROUP_W:0]    sh_l, sh_r;
  logic                ge_l, ge_r;
  logic [GROUP_W-1:0]  nrem_l, nrem_r;
  logic [SUM_W-1:0]    abs_l, abs_r;
  logic [SMP_W-1:0]    q_l, q_r;
  logic [FRAC_W:0]     tf_sum;
  logic                tf_ovf;

  // sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

  // next state and step strobes
  always_comb begin
    state_d = state_q;
    load    = 1'b0;
    step    = 1'b0;
    wr_out  = 1'b0;
    unique case (state_q)
      ST_IDLE: if (!empty_i) begin
        load    = 1'b1;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        step = 1'b1;
        if (step_q == LastStep) state_d = ST_DONE;
      end
      ST_DONE: if (!out_valid_q || out_ready_i) begin
        wr_out  = 1'b1;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign pop_o = load;

  // magnitudes of the incoming sums
  assign abs_l = grp_i.sum_l[SUM_W-1] ? SUM_W'(-grp_i.sum_l) : grp_i.sum_l;
  assign abs_r = grp_i.sum_r[SUM_W-1] ? SUM_W'(-grp_i.sum_r) : grp_i.sum_r;

  // one restoring step per lane
  always_comb begin
    sh_l   = {rem_l_q, dvd_l_q[MAG_W-1]};
    sh_r   = {rem_r_q, dvd_r_q[MAG_W-1]};
    ge_l   = (sh_l >= {1'b0, div_q});
    ge_r   = (sh_r >= {1'b0, div_q});
    nrem_l = ge_l ? GROUP_W'(sh_l - {1'b0, div_q}) : sh_l[GROUP_W-1:0];
    nrem_r = ge_r ? GROUP_W'(sh_r - {1'b0, div_q}) : sh_r[GROUP_W-1:0];
  end

  // divider datapath
  always_ff @(posedge clk_i) begin
    if (load) begin
      dvd_l_q <= abs_l[MAG_W-1:0];
      dvd_r_q <= abs_r[MAG_W-1:0];
      rem_l_q <= '0;
      rem_r_q <= '0;
      div_q   <= grp_i.cnt;
      neg_l_q <= grp_i.sum_l[SUM_W-1];
      neg_r_q <= grp_i.sum_r[SUM_W-1];
    end else if (step) begin
      dvd_l_q <= {dvd_l_q[MAG_W-2:0], ge_l};
      dvd_r_q <= {dvd_r_q[MAG_W-2:0], ge_r};
      rem_l_q <= nrem_l;
      rem_r_q <= nrem_r;
    end
  end

  // step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)   step_q <= '0;
    else if (load) step_q <= '0;
    else if (step) step_q <= step_q + StepW'(1);
  end

  // signed quotients, truncated toward zero
  assign q_l = neg_l_q ? SMP_W'(-dvd_l_q[SMP_W-1:0]) : dvd_l_q[SMP_W-1:0];
  assign q_r = neg_r_q ? SMP_W'(-dvd_r_q[SMP_W-1:0]) : dvd_r_q[SMP_W-1:0];

  // elapsed time in tenths of a second
  assign tf_sum = {1'b0, tfrac_q} + (FRAC_W + 1)'(TIME_STEP);
  assign tf_ovf = (tf_sum >= OutRateV);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tfrac_q  <= '0;
      tenths_q <= '0;
    end else if (wr_out) begin
      tfrac_q <= tf_ovf ? FRAC_W'(tf_sum - OutRateV) : tf_sum[FRAC_W-1:0];
      if (tf_ovf) tenths_q <= tenths_q + TENTHS_W'(1);
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (wr_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_out) begin
      out_l_q   <= $signed(q_l);
      out_r_q   <= $signed(q_r);
      elapsed_q <= tf_ovf ? tenths_q + TENTHS_W'(1) : tenths_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_left_o  = out_l_q;
  assign out_right_o = out_r_q;
  assign elapsed_o   = elapsed_q;

endmodule

`default_nettype wire

// ----- sim/pcm_box_decimator_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pcm_box_decimator_checker
// Passive monitor for the box decimator. It tracks register writes, predicts
// the averaged output sample of every completed group of source frames, and
// compares each output transfer field by field with the oldest prediction.
// ----------------------------------------------------------------------------

module pcm_box_decimator_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          src_valid_i,
  input  logic                          src_ready_i,
  input  logic [47:0]                   src_data_i,   // raw_left, raw_right
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic [55:0]                   out_data_i,   // out_left, out_right, elapsed_tenths
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [pbd_pkg::REG_IDX_W-1:0] cfg_index_i,
  input  logic [pbd_pkg::RATE_W-1:0]    cfg_data_i,
  output int                            errors_o,
  output int                            pending_o
);
  import pbd_pkg::*;

  // one averaged output sample, laid out as on the output bus
  typedef struct packed {
    logic [TENTHS_W-1:0]    tenths;
    logic signed [SMP_W-1:0] right;
    logic signed [SMP_W-1:0] left;
  } avg_sample_t;

  avg_sample_t expected_avgs[$];
  int          mismatches;

  // shadow of the block configuration
  logic [SB_W-1:0] width_bytes;
  logic            mono;
  int unsigned     rate_whole;
  int unsigned     rate_rem;

  // shadow of the accumulation state
  int unsigned         rate_acc;
  int unsigned         time_acc;
  int unsigned         frames;
  int unsigned         target;
  int                  sum_l;
  int                  sum_r;
  logic [TENTHS_W-1:0] tenths;

  // raw little-endian bytes down to a signed 16-bit sample
  function automatic logic signed [SMP_W-1:0] pcm16(input logic [SB_W-1:0] nbytes,
                                                    input logic [RAW_W-1:0] raw);
    logic [7:0] b0, b1, b2;
    b0 = raw[7:0];
    b1 = raw[15:8];
    b2 = raw[23:16];
    case (nbytes)
      2'd1:    return {b0, 8'h00};
      2'd2:    return {b1, b0};
      2'd3:    return {b2, b1};
      default: return '0;
    endcase
  endfunction

  // update the shadow registers for one register write
  task automatic apply_write(input logic [REG_IDX_W-1:0] idx, input logic [RATE_W-1:0] val);
    case (idx)
      REG_SAMPLE_BYTES: width_bytes = val[SB_W-1:0];
      REG_MONO_SOURCE:  mono = val[0];
      REG_SOURCE_RATE: begin
        rate_whole = int'(val) / OUT_RATE_DEF;
        rate_rem   = int'(val) % OUT_RATE_DEF;
        rate_acc   = 0;
      end
      default: ;
    endcase
  endtask

  // accumulate one source frame, queue an average when its group is full
  task automatic accumulate_frame(input logic [RAW_W-1:0] raw_l, input logic [RAW_W-1:0] raw_r);
    int unsigned             size;
    logic signed [SMP_W-1:0] l, r;
    avg_sample_t             avg;
    if (frames == 0) begin
      size = rate_whole;
      rate_acc += rate_rem;
      if (rate_acc >= OUT_RATE_DEF) begin
        rate_acc -= OUT_RATE_DEF;
        size++;
      end
      if (size < 1) size = 1;
      if (size > MAX_GROUP_DEF) size = MAX_GROUP_DEF;
      target = size;
      sum_l  = 0;
      sum_r  = 0;
    end
    l = pcm16(width_bytes, raw_l);
    r = mono ? l : pcm16(width_bytes, raw_r);
    sum_l += int'(l);
    sum_r += int'(r);
    frames++;
    if (frames >= target) begin
      avg.left  = SMP_W'(sum_l / int'(frames));
      avg.right = SMP_W'(sum_r / int'(frames));
      time_acc += TIME_STEP;
      if (time_acc >= OUT_RATE_DEF) begin
        time_acc -= OUT_RATE_DEF;
        tenths = tenths + 1'b1;
      end
      avg.tenths = tenths;
      expected_avgs.push_back(avg);
      frames = 0;
      sum_l  = 0;
      sum_r  = 0;
    end
  endtask

  // watch all three channels at each edge
  always @(posedge clk_i or negedge rst_ni) begin
    avg_sample_t got, want;
    if (!rst_ni) begin
      expected_avgs.delete();
      mismatches  = 0;
      width_bytes = SB_W'(SAMPLE_BYTES_RST);
      mono        = 1'b0;
      rate_whole  = SRC_RATE_RST / OUT_RATE_DEF;
      rate_rem    = SRC_RATE_RST % OUT_RATE_DEF;
      rate_acc    = 0;
      time_acc    = 0;
      frames      = 0;
      target      = 0;
      sum_l       = 0;
      sum_r       = 0;
      tenths      = '0;
      errors_o    <= 0;
      pending_o   <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) apply_write(cfg_index_i, cfg_data_i);
      // output transfer is checked before the frame of this edge is counted
      if (out_valid_i && out_ready_i) begin
        got = avg_sample_t'(out_data_i);
        if (expected_avgs.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected output, got left %0d right %0d tenths %0d",
                   $time, got.left, got.right, got.tenths);
        end else begin
          want = expected_avgs.pop_front();
          if (got.left !== want.left || got.right !== want.right ||
              got.tenths !== want.tenths) begin
            mismatches++;
            $display("%0t: output mismatch, expected left %0d right %0d tenths %0d,",
                     $time, want.left, want.right, want.tenths,
                     " got left %0d right %0d tenths %0d", got.left, got.right, got.tenths);
          end
        end
      end
      if (src_valid_i && src_ready_i) accumulate_frame(src_data_i[23:0], src_data_i[47:24]);
      errors_o  <= mismatches;
      pending_o <= expected_avgs.size();
    end
  end

endmodule

// ----- sim/pcm_box_decimator_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pcm_box_decimator_tb
// Drives source frames and register writes into the box decimator with random
// gaps and output backpressure. A directed set covers sample widths, sign
// extremes, mono, group sizes and a mid-group write; random phases follow,
// each with fresh register settings. The checker scores every output.
// ----------------------------------------------------------------------------

module pcm_box_decimator_tb;
  import pbd_pkg::*;

  // index with no register behind it
  localparam logic [REG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int DRAIN_CYCLES = 50;
  localparam int STALL_LIMIT  = 2000;
  localparam int PHASES       = 8;
  localparam int PHASE_FRAMES = 60;

  logic                 clk_i      = 1'b0;
  logic                 rst_ni     = 1'b0;
  logic                 src_valid  = 1'b0;
  logic                 src_ready;
  logic [47:0]          src_data   = '0;
  logic                 out_valid;
  logic                 out_ready  = 1'b0;
  logic [55:0]          out_data;
  logic                 cfg_valid  = 1'b0;
  logic                 cfg_ready;
  logic [REG_IDX_W-1:0] cfg_index  = '0;
  logic [RATE_W-1:0]    cfg_data   = '0;
  logic                 no_gaps    = 1'b0;
  int                   errors;
  int                   pending;

  pcm_box_decimator dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (src_valid),
    .s_axis_tready (src_ready),
    .s_axis_tdata  (src_data),
    .m_axis_tvalid (out_valid),
    .m_axis_tready (out_ready),
    .m_axis_tdata  (out_data),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  pcm_box_decimator_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .src_valid_i (src_valid),
    .src_ready_i (src_ready),
    .src_data_i  (src_data),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_data_i  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .errors_o    (errors),
    .pending_o   (pending)
  );

  // clock
  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // output backpressure
  always @(posedge clk_i) begin
    out_ready <= no_gaps || ($urandom_range(99) >= 25);
  end

  // stop the source and wait until every average has come out
  task automatic settle();
    src_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // register write, only ever issued once the source is stopped and every pending average has come out
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [RATE_W-1:0] val);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // one source frame transfer, with random idle cycles ahead of it
  task automatic send_frame(input logic [RAW_W-1:0] raw_l, input logic [RAW_W-1:0] raw_r);
    while (!no_gaps && $urandom_range(99) < 25) begin
      src_valid <= 1'b0;
      @(posedge clk_i);
    end
    src_valid <= 1'b1;
    src_data  <= {raw_r, raw_l};
    do @(posedge clk_i); while (!src_ready);
  endtask

  // raw sample bytes, leaning toward sign extremes now and then
  function automatic logic [RAW_W-1:0] random_raw();
    case ($urandom_range(9))
      0:       return 24'h000000;
      1:       return 24'hFFFFFF;
      2:       return 24'h7F7F7F;
      3:       return 24'h808080;
      default: return RAW_W'($urandom);
    endcase
  endfunction

  // source rate, including zero, the register maximum and exact multiples
  function automatic logic [RATE_W-1:0] random_rate();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      2:       return RATE_W'(192000);
      3:       return RATE_W'(44100);
      4:       return RATE_W'(88200);
      5:       return RATE_W'($urandom_range(1, 8000));
      default: return RATE_W'($urandom_range(8000, 192000));
    endcase
  endfunction

  // stall watchdog
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((src_valid && src_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("pcm_box_decimator_tb failed");
    $finish;
  end

  // stimulus
  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: 16-bit stereo, one frame per group
    send_frame(24'h000000, 24'h000000);
    send_frame(24'hFFFFFF, 24'hFFFFFF);
    send_frame(24'h007FFF, 24'h008000);

    // 8-bit samples land in the high byte
    write_reg(REG_SAMPLE_BYTES, 1);
    send_frame(24'h00007F, 24'h000080);
    send_frame(24'hFFFFFF, 24'h000000);

    // 24-bit samples keep the top two bytes
    write_reg(REG_SAMPLE_BYTES, 3);
    send_frame(24'h7FFF00, 24'h800000);
    send_frame(24'hFFFFFF, 24'h00FFFF);

    // zero sample width reads as silence
    write_reg(REG_SAMPLE_BYTES, 0);
    send_frame(24'h123456, 24'hFEDCBA);

    // mono copies left into right
    write_reg(REG_SAMPLE_BYTES, 2);
    write_reg(REG_MONO_SOURCE, 1);
    send_frame(24'h001234, 24'h00ABCD);

    // three-frame groups at full scale
    write_reg(REG_MONO_SOURCE, 0);
    write_reg(REG_SOURCE_RATE, 132300);
    repeat (3) send_frame(24'h008000, 24'h007FFF);

    // zero rate still gives one-frame groups
    write_reg(REG_SOURCE_RATE, 0);
    send_frame(24'h000001, 24'hFFFFFF);

    // largest rate: groups of five and six, one frame left open
    write_reg(REG_SOURCE_RATE, '1);
    repeat (6) send_frame(24'h007FFF, 24'h008001);

    // writes inside an open group leave its size and sums alone
    write_reg(REG_SAMPLE_BYTES, 3);
    write_reg(REG_SPARE, '1);
    repeat (5) send_frame(24'h7FFF00, 24'h800100);

    // tiny rate clears the remainder and falls back to one frame
    write_reg(REG_SOURCE_RATE, 1);
    send_frame(24'hA5A5A5, 24'h5A5A5A);

    // random phases, the first one without idle cycles
    for (int ph = 0; ph < PHASES; ph++) begin
      no_gaps <= (ph == 0);
      write_reg(REG_SAMPLE_BYTES,
                RATE_W'(($urandom_range(7) == 0) ? 0 : $urandom_range(1, 3)));
      if (ph % 3 == 2) write_reg(REG_SPARE, RATE_W'($urandom));
      write_reg(REG_MONO_SOURCE, RATE_W'($urandom_range(1)));
      write_reg(REG_SOURCE_RATE, random_rate());
      repeat (PHASE_FRAMES) send_frame(random_raw(), random_raw());
    end

    no_gaps <= 1'b0;
    settle();
    if (errors == 0)
      $display("pcm_box_decimator_tb passed");
    else
      $display("pcm_box_decimator_tb failed");
    $finish;
  end

endmodule
